>>> rtl/rtc3w_pkg.sv
package rtc3w_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Width of the phase counter; the transaction closes when its top bit sets
    localparam int unsigned PHASE_W = 6;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] address;
        logic [6:0] value;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       rst_pin;
        logic       sck_pin;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] read_value;
        logic       done_res;
        logic       start_rejected;
    } result_t;

    typedef struct packed {
        logic busy;
        logic is_read;
    } status_t;

    // Binary 0..127 to packed BCD; tens may reach 12 and still lands in the high nibble
    function automatic logic [7:0] bcd_encode(input logic [6:0] v);
        logic [17:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = {11'd0, v} * 18'd205;
        tens  = prod[14:11];
        units = v - 7'({tens, 3'b000} + {2'b00, tens, 1'b0});
        return {tens, units[3:0]};
    endfunction

    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi_x10;
        hi_x10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
        return hi_x10 + {4'd0, b[3:0]};
    endfunction

endpackage

>>> rtl/rtc3w_core.sv
module rtc3w_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  rtc3w_pkg::item_t    item,
    output rtc3w_pkg::result_t  result,
    output rtc3w_pkg::status_t  status
);

    logic                              busy_reg, busy_next;
    logic                              is_read_reg, is_read_next;
    logic [rtc3w_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [15:0]                       shift_out_reg, shift_out_next;
    logic [7:0]                        shift_in_reg, shift_in_next;
    logic                              rst_reg, rst_next;
    logic                              sck_reg, sck_next;
    logic                              sda_reg, sda_next;

    logic       is_start;
    logic       drive;
    logic       done;
    logic       rej;
    logic [3:0] bit_idx;
    logic [7:0] cmd_byte;

    assign is_start = (item.command == rtc3w_pkg::CMD_WRITE) ||
                      (item.command == rtc3w_pkg::CMD_READ);
    assign bit_idx  = phase_reg[4:1];

    always_comb begin
        busy_next      = busy_reg;
        is_read_next   = is_read_reg;
        phase_next     = phase_reg;
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        rst_next       = rst_reg;
        sck_next       = sck_reg;
        sda_next       = sda_reg;
        drive          = 1'b1;
        done           = 1'b0;
        rej            = 1'b0;
        cmd_byte       = item.address;

        if (!busy_reg && is_start) begin
            is_read_next = (item.command == rtc3w_pkg::CMD_READ);
            if (is_read_next) begin
                cmd_byte       = item.address | 8'h01;
                shift_out_next = {8'h00, cmd_byte};
            end else begin
                cmd_byte       = item.address & 8'hFE;
                shift_out_next = {rtc3w_pkg::bcd_encode(item.value), cmd_byte};
            end
            phase_next = '0;
            busy_next  = 1'b1;
            rst_next   = 1'b0;
            sck_next   = 1'b0;
            sda_next   = 1'b0;
        end else begin
            rej = busy_reg && is_start;
            if (busy_reg) begin
                if (phase_reg[rtc3w_pkg::PHASE_W-1]) begin
                    // close the transaction: drop enable and clock
                    rst_next   = 1'b0;
                    sck_next   = 1'b0;
                    sda_next   = 1'b0;
                    busy_next  = 1'b0;
                    phase_next = '0;
                    done       = 1'b1;
                end else begin
                    rst_next = 1'b1;
                    sck_next = phase_reg[0];
                    if (is_read_reg && bit_idx[3]) begin
                        // release the pin; sample before the clock rises
                        drive    = 1'b0;
                        sda_next = 1'b0;
                        if (!phase_reg[0]) begin
                            shift_in_next = {item.sda_in, shift_in_reg[7:1]};
                        end
                    end else begin
                        sda_next = shift_out_reg[bit_idx];
                    end
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            is_read_reg   <= 1'b0;
            phase_reg     <= '0;
            shift_out_reg <= '0;
            shift_in_reg  <= '0;
            rst_reg       <= 1'b0;
            sck_reg       <= 1'b0;
            sda_reg       <= 1'b0;
        end else if (step_en) begin
            busy_reg      <= busy_next;
            is_read_reg   <= is_read_next;
            phase_reg     <= phase_next;
            shift_out_reg <= shift_out_next;
            shift_in_reg  <= shift_in_next;
            rst_reg       <= rst_next;
            sck_reg       <= sck_next;
            sda_reg       <= sda_next;
        end
    end

    always_comb begin
        result.rst_pin        = rst_next;
        result.sck_pin        = sck_next;
        result.sda_out        = drive & sda_next;
        result.sda_drive      = drive;
        result.read_value     = rtc3w_pkg::bcd_decode(shift_in_next);
        result.done_res       = done;
        result.start_rejected = rej;
    end

    assign status.busy    = busy_reg;
    assign status.is_read = is_read_reg;

endmodule

>>> rtl/rtc_three_wire_master_unit.sv
// Three-wire RTC link master, stepped one pin-level tick per input transaction.
// Input channel (s_valid/s_ready): s_command is tick, start write or start read;
// s_address is the register command byte (bit 0 set by the kind), s_value the
// decimal value sent as packed BCD, s_sda_in the sampled data pin level.
// Output channel (m_valid/m_ready): one result per input transaction with the
// pin levels rst/sck/sda, the data pin drive enable, the BCD-decoded read byte,
// a done flag on the closing tick and a flag for a start that arrived while busy.
// A transaction takes 34 input items: the start, 32 clocking phases, the close.
// The input is registered, then one pass of link logic leads into the result
// register that drives m_valid.
// Throughput: one item per clock while the receiver takes every result; the
// link state updates once per item.
// When the receiver stalls, the result register holds, the input register
// fills, and s_ready drops until m_ready frees the result slot.
// Reset (aresetn low, synchronous) empties both registers and returns the
// link to idle with all pins low and the read byte cleared.
module rtc_three_wire_master_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_address,
    input  logic [6:0] s_value,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_rst_pin,
    output logic       m_sck_pin,
    output logic       m_sda_out,
    output logic       m_sda_drive,
    output logic [7:0] m_read_value,
    output logic       m_done_res,
    output logic       m_start_rejected
);

    logic                in_valid_reg, in_valid_next;
    rtc3w_pkg::item_t    in_item_reg;
    logic                out_valid_reg, out_valid_next;
    rtc3w_pkg::result_t  out_reg;
    rtc3w_pkg::result_t  core_result;
    rtc3w_pkg::status_t  core_status;
    logic                step;
    logic                s_fire;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign s_fire  = s_valid && s_ready;

    rtc3w_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .item    (in_item_reg),
        .result  (core_result),
        .status  (core_status)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.command <= s_command;
            in_item_reg.address <= s_address;
            in_item_reg.value   <= s_value;
            in_item_reg.sda_in  <= s_sda_in;
        end
        if (step) begin
            out_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_rst_pin        = out_reg.rst_pin;
    assign m_sck_pin        = out_reg.sck_pin;
    assign m_sda_out        = out_reg.sda_out;
    assign m_sda_drive      = out_reg.sda_drive;
    assign m_read_value     = out_reg.read_value;
    assign m_done_res       = out_reg.done_res;
    assign m_start_rejected = out_reg.start_rejected;

    a_done_drops_enable : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_rst_pin && !m_sck_pin)
        else $error("done result with link still enabled");

    a_released_pin_low : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sda_drive |-> !m_sda_out && m_rst_pin)
        else $error("released data pin outside an active read");

    a_start_sets_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        step && !core_status.busy &&
        (in_item_reg.command == rtc3w_pkg::CMD_WRITE ||
         in_item_reg.command == rtc3w_pkg::CMD_READ)
        |=> core_status.busy)
        else $error("accepted start did not open a transaction");

    a_reject_only_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        step && core_result.start_rejected |-> core_status.busy)
        else $error("start rejected while idle");

endmodule

>>> verif/rtc_three_wire_master_unit_tb.sv
`timescale 1ns / 100ps

module rtc_three_wire_master_unit_tb;

    // Unused command code; the block treats it as a tick
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT = 200000;

    class pin_tick_board;
        bit                  busy;
        bit                  reading;
        bit [5:0]            phase;
        bit [15:0]           out_bits;
        bit [7:0]            in_byte;
        bit [2:0]            pins;
        rtc3w_pkg::result_t  pin_levels_due[$];
        int                  errors;
        int                  checked;
        int                  writes;
        int                  reads;
        int                  rejects;

        task report(string what, logic [7:0] got, logic [7:0] want);
            errors++;
            $display("MISMATCH #%0d after %0d results, %s: got %0d, expected %0d",
                     errors, checked, what, got, want);
        endtask

        // Advance the link by one tick and queue the pin levels it should produce.
        function void note_tick(logic [1:0] cmd, logic [7:0] addr, logic [6:0] val,
                                logic sda);
            rtc3w_pkg::result_t  want;
            bit       start;
            bit       drive;
            bit       fin;
            bit       rej;
            bit       sck;
            bit       lvl;
            bit [3:0] bit_idx;
            bit [6:0] tens;
            bit [6:0] units;
            bit [7:0] cmd_byte;
            bit [7:0] data;
            start = (cmd == rtc3w_pkg::CMD_WRITE) || (cmd == rtc3w_pkg::CMD_READ);
            drive = 1'b1;
            fin = 1'b0;
            rej = 1'b0;
            if (!busy && start) begin
                reading = (cmd == rtc3w_pkg::CMD_READ);
                cmd_byte = reading ? (addr | 8'h01) : (addr & 8'hFE);
                tens = val / 7'd10;
                units = val % 7'd10;
                data = reading ? 8'h00 : {tens[3:0], units[3:0]};
                out_bits = {data, cmd_byte};
                phase = '0;
                busy = 1'b1;
                pins = '0;
                if (reading)
                    reads++;
                else
                    writes++;
            end else begin
                if (busy && start) begin
                    rej = 1'b1;
                    rejects++;
                end
                if (busy) begin
                    if (phase >= 6'd32) begin
                        pins = '0;
                        busy = 1'b0;
                        phase = '0;
                        fin = 1'b1;
                    end else begin
                        bit_idx = phase[4:1];
                        sck = phase[0];
                        if (reading && bit_idx >= 4'd8) begin
                            // data pin released; sample before the clock rises
                            drive = 1'b0;
                            lvl = 1'b0;
                            if (!sck)
                                in_byte = {sda, in_byte[7:1]};
                        end else begin
                            lvl = out_bits[bit_idx];
                        end
                        pins = {lvl, sck, 1'b1};
                        phase = phase + 6'd1;
                    end
                end
            end
            want.rst_pin = pins[0];
            want.sck_pin = pins[1];
            want.sda_out = drive ? pins[2] : 1'b0;
            want.sda_drive = drive;
            want.read_value = {4'd0, in_byte[7:4]} * 8'd10 + {4'd0, in_byte[3:0]};
            want.done_res = fin;
            want.start_rejected = rej;
            pin_levels_due.push_back(want);
        endfunction

        task check_pins(rtc3w_pkg::result_t got);
            rtc3w_pkg::result_t want;
            if (pin_levels_due.size() == 0) begin
                report("result with nothing pending", 8'd0, 8'd0);
                return;
            end
            want = pin_levels_due.pop_front();
            checked++;
            if (got.rst_pin !== want.rst_pin)
                report("rst_pin", {7'd0, got.rst_pin}, {7'd0, want.rst_pin});
            if (got.sck_pin !== want.sck_pin)
                report("sck_pin", {7'd0, got.sck_pin}, {7'd0, want.sck_pin});
            if (got.sda_out !== want.sda_out)
                report("sda_out", {7'd0, got.sda_out}, {7'd0, want.sda_out});
            if (got.sda_drive !== want.sda_drive)
                report("sda_drive", {7'd0, got.sda_drive}, {7'd0, want.sda_drive});
            if (got.read_value !== want.read_value)
                report("read_value", got.read_value, want.read_value);
            if (got.done_res !== want.done_res)
                report("done_res", {7'd0, got.done_res}, {7'd0, want.done_res});
            if (got.start_rejected !== want.start_rejected)
                report("start_rejected", {7'd0, got.start_rejected},
                       {7'd0, want.start_rejected});
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_command;
    logic [7:0] s_address;
    logic [6:0] s_value;
    logic       s_sda_in;
    logic       m_valid;
    logic       m_ready;
    logic       m_rst_pin;
    logic       m_sck_pin;
    logic       m_sda_out;
    logic       m_sda_drive;
    logic [7:0] m_read_value;
    logic       m_done_res;
    logic       m_start_rejected;

    pin_tick_board board = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int cycles = 0;

    rtc_three_wire_master_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_address        (s_address),
        .s_value          (s_value),
        .s_sda_in         (s_sda_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rst_pin        (m_rst_pin),
        .m_sck_pin        (m_sck_pin),
        .m_sda_out        (m_sda_out),
        .m_sda_drive      (m_sda_drive),
        .m_read_value     (m_read_value),
        .m_done_res       (m_done_res),
        .m_start_rejected (m_start_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycles, board.pin_levels_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // Result side: check each accepted transaction, stall at random.
    initial begin
        rtc3w_pkg::result_t got;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                got = '{rst_pin: m_rst_pin, sck_pin: m_sck_pin, sda_out: m_sda_out,
                        sda_drive: m_sda_drive, read_value: m_read_value,
                        done_res: m_done_res, start_rejected: m_start_rejected};
                board.check_pins(got);
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [7:0] addr, logic [6:0] val,
                             logic sda);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_address <= addr;
        s_value <= val;
        s_sda_in <= sda;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        board.note_tick(cmd, addr, val, sda);
        items_sent++;
    endtask

    // One start followed by the 33 ticks that carry it to done; some ticks
    // are replaced by stray starts or the spare code when noise is asked for.
    task automatic run_transfer(logic [1:0] kind, logic [7:0] addr, logic [6:0] val,
                                logic [7:0] rbyte, int noise_pct);
        logic [1:0] cmd;
        logic       sda;
        send_item(kind, addr, val, 1'($urandom_range(1)));
        for (int p = 0; p <= 32; p++) begin
            cmd = rtc3w_pkg::CMD_TICK;
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0: cmd = rtc3w_pkg::CMD_WRITE;
                    1: cmd = rtc3w_pkg::CMD_READ;
                    default: cmd = CMD_SPARE;
                endcase
            end
            sda = 1'($urandom_range(1));
            if (p >= 16 && p < 32 && p % 2 == 0)
                sda = rbyte[(p - 16) / 2];
            send_item(cmd, 8'($urandom_range(255)), 7'($urandom_range(127)), sda);
        end
    endtask

    initial begin
        int         rand_base;
        int         stage;
        logic [1:0] kind;
        logic [6:0] val;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_command <= rtc3w_pkg::CMD_TICK;
        s_address <= '0;
        s_value <= '0;
        s_sda_in <= 1'b0;
        m_ready <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle ticks, widest write with stray starts, all-ones read, zero write
        send_item(rtc3w_pkg::CMD_TICK, 8'hFF, 7'h7F, 1'b1);
        send_item(CMD_SPARE, 8'h00, 7'h00, 1'b0);
        run_transfer(rtc3w_pkg::CMD_WRITE, 8'hFF, 7'd127, 8'h00, 20);
        run_transfer(rtc3w_pkg::CMD_READ, 8'h00, 7'd99, 8'hFF, 0);
        run_transfer(rtc3w_pkg::CMD_WRITE, 8'h00, 7'd0, 8'h00, 0);

        rand_base = items_sent;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            stage = (items_sent - rand_base) * 4 / RANDOM_ITEMS;
            case (stage)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 60; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 60; end
                default: begin gap_pct = 22; stall_pct = 22; end
            endcase
            // occasional ticks while idle between transactions
            repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
                send_item($urandom_range(1) ? rtc3w_pkg::CMD_TICK : CMD_SPARE,
                          8'($urandom_range(255)), 7'($urandom_range(127)),
                          1'($urandom_range(1)));
            kind = $urandom_range(1) ? rtc3w_pkg::CMD_READ : rtc3w_pkg::CMD_WRITE;
            val = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 100))
                                            : 7'($urandom_range(99));
            run_transfer(kind, 8'($urandom_range(255)), val, 8'($urandom_range(255)),
                         ($urandom_range(3) == 0) ? 8 : 0);
        end
        s_valid <= 1'b0;

        while (board.pin_levels_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d ticks sent, %0d results checked in %0d cycles",
                 items_sent, board.checked, cycles);
        $display("%0d write and %0d read transactions, %0d starts turned away while busy",
                 board.writes, board.reads, board.rejects);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
